FILE: rtl/plhct_pkg.sv
`default_nettype none

package plhct_pkg;

  localparam int unsigned GapWidth    = 10;
  localparam int unsigned CountWidth  = 5;
  localparam int unsigned KeyWidth    = 5;
  localparam int unsigned HouseWidth  = 4;
  localparam int unsigned LetterWidth = 8;

  localparam logic [GapWidth-1:0]   GapReset   = 10'd120;
  localparam logic [CountWidth-1:0] FrameLast  = 5'd27;   // 28 ticks per frame
  localparam logic [CountWidth-1:0] StartZero  = 5'd3;    // fourth start bit is a zero
  localparam logic [CountWidth-1:0] HouseStart = 5'd4;
  localparam logic [CountWidth-1:0] KeyStart   = 5'd12;
  localparam logic [CountWidth-1:0] KeyEnd     = 5'd22;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ADDR1 = 3'd1,
    PH_ADDR2 = 3'd2,
    PH_GAP   = 3'd3,
    PH_FUNC1 = 3'd4,
    PH_FUNC2 = 3'd5
  } phase_t;

  typedef struct packed {
    logic                  found;
    logic [HouseWidth-1:0] index;
  } house_t;

  // ascii A..P to house index, anything else not found
  function automatic house_t house_lookup(input logic [LetterWidth-1:0] letter);
    house_t h;
    h.found = 1'b1;
    case (letter)
      8'h41:   h.index = 4'd6;   // A
      8'h42:   h.index = 4'd7;   // B
      8'h43:   h.index = 4'd4;   // C
      8'h44:   h.index = 4'd5;   // D
      8'h45:   h.index = 4'd8;   // E
      8'h46:   h.index = 4'd9;   // F
      8'h47:   h.index = 4'd10;  // G
      8'h48:   h.index = 4'd11;  // H
      8'h49:   h.index = 4'd14;  // I
      8'h4A:   h.index = 4'd15;  // J
      8'h4B:   h.index = 4'd12;  // K
      8'h4C:   h.index = 4'd13;  // L
      8'h4D:   h.index = 4'd0;   // M
      8'h4E:   h.index = 4'd1;   // N
      8'h4F:   h.index = 4'd2;   // O
      8'h50:   h.index = 4'd3;   // P
      default: begin
        h.found = 1'b0;
        h.index = 4'd0;
      end
    endcase
    return h;
  endfunction

  // unit and function codes 0..16 go through the key table, the rest pass raw
  function automatic logic [KeyWidth-1:0] map_key(input logic [KeyWidth-1:0] code);
    logic [KeyWidth-1:0] k;
    case (code)
      5'd0:    k = 5'd16;
      5'd1:    k = 5'd6;
      5'd2:    k = 5'd7;
      5'd3:    k = 5'd4;
      5'd4:    k = 5'd5;
      5'd5:    k = 5'd8;
      5'd6:    k = 5'd9;
      5'd7:    k = 5'd10;
      5'd8:    k = 5'd11;
      5'd9:    k = 5'd14;
      5'd10:   k = 5'd15;
      5'd11:   k = 5'd12;
      5'd12:   k = 5'd13;
      5'd13:   k = 5'd0;
      5'd14:   k = 5'd1;
      5'd15:   k = 5'd2;
      5'd16:   k = 5'd3;
      default: k = code;
    endcase
    return k;
  endfunction

  // bit sent at a frame position; every data bit is followed by its complement
  function automatic logic frame_bit(input logic [CountWidth-1:0] pos,
                                     input logic [HouseWidth-1:0] house,
                                     input logic [KeyWidth-1:0]   key);
    logic [CountWidth-1:0] off;
    logic                  b;
    if (pos < StartZero) begin
      b = 1'b1;
    end else if (pos < HouseStart) begin
      b = 1'b0;
    end else if (pos < KeyStart) begin
      off = pos - HouseStart;
      b   = house[off[2:1]] ^ off[0];
    end else if (pos < KeyEnd) begin
      off = pos - KeyStart;
      b   = key[off[3:1]] ^ off[0];
    end else begin
      b = 1'b0;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/powerline_home_code_transmitter.sv
`default_nettype none

// Powerline home-code transmitter. Each input beat is either a zero-crossing
// tick (s_tuser = 0) or a send request (s_tuser = 1) carrying a house letter
// A..P and two 5-bit codes. After an accepted send, each tick yields one bit
// on burst: the address frame twice, gap_crossings silent ticks, then the
// function frame twice. A frame is 28 ticks: start bits 1110, house index and
// key LSB first with every bit followed by its complement, then six silent
// ticks. Codes 0..16 go through the key table (0 meaning unit 16), codes
// 17..31 are sent raw. A send with an unknown letter or while a sequence is
// running is refused and flagged on rejected. Every input beat produces
// exactly one result beat, in the cycle after it is taken. The sequencer
// step, a table lookup and counter update, is combinational, so a beat can be
// taken every clock; the only thing that holds s_tready low is a result still
// waiting in the single output register while m_tready is low. The carrier
// burst length on the line is left to the pin driver. Write gap_crossings
// (reset 120) via cfg_we/cfg_data only when no sequence runs; not enforced.
module powerline_home_code_transmitter
  import plhct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        cfg_we,
  input  wire logic [9:0]  cfg_data,   // gap_crossings

  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,    // house_letter[7:0], address_code[12:8],
                                       // function_code[17:13], zero fill
  input  wire logic        s_tuser,    // command: 0 tick, 1 send

  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata     // burst[0], busy_res[1], rejected[2],
                                       // done_res[3], zero fill
);

  // configuration
  logic [GapWidth-1:0]   gap_crossings;

  // sequencer state
  phase_t                phase, phase_next;
  logic [CountWidth-1:0] crossing_count, crossing_count_next;
  logic [GapWidth-1:0]   gap_count, gap_count_next;
  logic [HouseWidth-1:0] house_index, house_index_next;
  logic [KeyWidth-1:0]   address_bits, address_bits_next;
  logic [KeyWidth-1:0]   function_bits, function_bits_next;

  // result of this beat
  logic                  res_burst, res_busy, res_rej, res_done;

  logic                  s_fire;
  logic                  active;
  house_t                house;
  logic [KeyWidth-1:0]   cur_key;
  logic [GapWidth-1:0]   gap_inc;

  // output register drains or is empty: take a beat
  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  assign active  = (phase == PH_ADDR1) || (phase == PH_ADDR2) || (phase == PH_GAP) ||
                   (phase == PH_FUNC1) || (phase == PH_FUNC2);
  assign house   = house_lookup(s_tdata[7:0]);
  assign cur_key = ((phase == PH_ADDR1) || (phase == PH_ADDR2)) ? address_bits
                                                                 : function_bits;
  assign gap_inc = gap_count + 1'b1;

  always_comb begin
    phase_next          = phase;
    crossing_count_next = crossing_count;
    gap_count_next      = gap_count;
    house_index_next    = house_index;
    address_bits_next   = address_bits;
    function_bits_next  = function_bits;
    res_burst           = 1'b0;
    res_busy            = 1'b0;
    res_rej             = 1'b0;
    res_done            = 1'b0;

    if (s_tuser) begin
      // send request
      if (active) begin
        res_rej  = 1'b1;
        res_busy = 1'b1;
      end else if (!house.found) begin
        res_rej = 1'b1;
      end else begin
        house_index_next    = house.index;
        address_bits_next   = map_key(s_tdata[12:8]);
        function_bits_next  = map_key(s_tdata[17:13]);
        phase_next          = PH_ADDR1;
        crossing_count_next = '0;
        gap_count_next      = '0;
        res_busy            = 1'b1;
      end
    end else if (active) begin
      // zero-crossing tick inside a sequence
      res_busy = 1'b1;
      if (phase == PH_GAP) begin
        gap_count_next = gap_inc;
        if (gap_inc >= gap_crossings) begin
          phase_next          = PH_FUNC1;
          crossing_count_next = '0;
        end
      end else begin
        res_burst           = frame_bit(crossing_count, house_index, cur_key);
        crossing_count_next = crossing_count + 1'b1;
        if (crossing_count == FrameLast) begin
          crossing_count_next = '0;
          case (phase)
            PH_ADDR1: phase_next = PH_ADDR2;
            PH_ADDR2: begin
              gap_count_next = '0;
              phase_next     = (gap_crossings == '0) ? PH_FUNC1 : PH_GAP;
            end
            PH_FUNC1: phase_next = PH_FUNC2;
            default: begin
              phase_next = PH_IDLE;
              res_done   = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_crossings  <= GapReset;
      phase          <= PH_IDLE;
      crossing_count <= '0;
      gap_count      <= '0;
      house_index    <= '0;
      address_bits   <= '0;
      function_bits  <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        gap_crossings <= cfg_data;
      end
      if (s_fire) begin
        phase          <= phase_next;
        crossing_count <= crossing_count_next;
        gap_count      <= gap_count_next;
        house_index    <= house_index_next;
        address_bits   <= address_bits_next;
        function_bits  <= function_bits_next;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload, loaded with each taken beat
  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_tdata <= {4'b0000, res_done, res_rej, res_busy, res_burst};
    end
  end

  // a finished sequence leaves the sequencer idle
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    (s_fire && res_done) |=> (phase == PH_IDLE))
    else $error("sequencer not idle after last frame");

  // crossing counter never runs past a frame
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    crossing_count <= FrameLast)
    else $error("crossing count out of frame");

  // a burst or done only comes out of a running, unrefused sequence
  a_burst_busy : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[0] || m_tdata[3])) |-> (m_tdata[1] && !m_tdata[2]))
    else $error("burst or done outside a sequence");

  // an accepted send always starts the first address frame
  a_send_start : assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_tuser && !res_rej) |=> (phase == PH_ADDR1 && crossing_count == '0))
    else $error("accepted send did not start the address frame");

endmodule

`default_nettype wire

FILE: verif/powerline_home_code_transmitter_tb.sv
`default_nettype none

module powerline_home_code_transmitter_tb;
  import plhct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one result beat as it sits in m_tdata[3:0]
  typedef struct packed {
    logic done;
    logic rejected;
    logic busy;
    logic burst;
  } line_out_t;

  // house letter per house index, index 0 in the lowest byte: M N O P C D A B E F G H K L I J
  localparam logic [15:0][7:0] HouseLetters = "JILKHGFEBADCPONM";

  // key sent for unit/function codes 0..16, code 0 meaning unit 16
  localparam logic [16:0][4:0] KeyOfCode = {
    5'd3, 5'd2, 5'd1, 5'd0, 5'd13, 5'd12, 5'd15, 5'd14,
    5'd11, 5'd10, 5'd9, 5'd8, 5'd5, 5'd4, 5'd7, 5'd6, 5'd16
  };

  localparam logic CmdTick = 1'b0;
  localparam logic CmdSend = 1'b1;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [9:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // house_letter[7:0], address_code[12:8], function_code[17:13]
  logic        s_tuser = 1'b0; // command: 0 tick, 1 send
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // burst[0], busy_res[1], rejected[2], done_res[3]

  powerline_home_code_transmitter u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // sequencer shadow state, advanced once per accepted input beat
  // ---------------------------------------------------------------------------
  phase_t     seq_phase = PH_IDLE;
  logic [4:0] tick_pos = '0;     // position inside the current frame
  logic [9:0] gap_ticks = '0;    // silent crossings counted so far in the gap
  logic [9:0] gap_reg = 10'd120; // gap_crossings register as last written
  logic [3:0] house_idx = '0;
  logic [4:0] addr_key = '0;
  logic [4:0] func_key = '0;

  line_out_t  pending_line_out[$]; // line outputs still owed by the block
  int         beats_sent = 0;
  int         err_count = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;

  function automatic logic [4:0] code_to_key(input logic [4:0] code);
    if (code > 5'd16) begin
      return code;  // raw codes pass unchanged
    end
    return KeyOfCode[code];
  endfunction

  // level on the line at one frame position: start 1110, then house and key
  // bits LSB first, each followed by its complement, then six silent crossings
  function automatic logic frame_level(input logic [4:0] pos, input logic [3:0] house,
                                       input logic [4:0] key);
    logic [27:0] frame;
    frame = '0;
    frame[2:0] = 3'b111;
    for (int i = 0; i < 4; i++) begin
      frame[4 + 2*i] = house[i];
      frame[5 + 2*i] = ~house[i];
    end
    for (int j = 0; j < 5; j++) begin
      frame[12 + 2*j] = key[j];
      frame[13 + 2*j] = ~key[j];
    end
    return frame[pos];
  endfunction

  function automatic line_out_t step_sequencer(input logic send, input logic [7:0] letter,
                                               input logic [4:0] acode, input logic [4:0] fcode);
    line_out_t r;
    logic      running;
    int        hit;
    logic [4:0] key;
    r = '0;
    running = (seq_phase >= PH_ADDR1) && (seq_phase <= PH_FUNC2);
    if (send) begin
      if (running) begin
        // refused, sequence carries on untouched
        r.rejected = 1'b1;
        r.busy     = 1'b1;
      end else begin
        hit = -1;
        for (int i = 15; i >= 0; i--) begin
          if (HouseLetters[i] == letter) hit = i;
        end
        if (hit < 0) begin
          r.rejected = 1'b1;
        end else begin
          house_idx = hit[3:0];
          addr_key  = code_to_key(acode);
          func_key  = code_to_key(fcode);
          seq_phase = PH_ADDR1;
          tick_pos  = '0;
          gap_ticks = '0;
          r.busy    = 1'b1;
        end
      end
    end else if (running) begin
      r.busy = 1'b1;
      if (seq_phase == PH_GAP) begin
        gap_ticks = gap_ticks + 10'd1;
        // a register lowered mid-gap ends the gap on the next crossing
        if (gap_ticks >= gap_reg) begin
          seq_phase = PH_FUNC1;
          tick_pos  = '0;
        end
      end else begin
        key = (seq_phase == PH_ADDR1 || seq_phase == PH_ADDR2) ? addr_key : func_key;
        r.burst = frame_level(tick_pos, house_idx, key);
        if (tick_pos == 5'd27) begin
          tick_pos = '0;
          case (seq_phase)
            PH_ADDR1: seq_phase = PH_ADDR2;
            PH_ADDR2: begin
              gap_ticks = '0;
              seq_phase = (gap_reg == '0) ? PH_FUNC1 : PH_GAP;
            end
            PH_FUNC1: seq_phase = PH_FUNC2;
            default: begin
              seq_phase = PH_IDLE;
              r.done    = 1'b1;
            end
          endcase
        end else begin
          tick_pos = tick_pos + 5'd1;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // present one beat, hold it until taken, then log what it should produce
  task automatic offer_beat(input logic cmd, input logic [7:0] letter,
                            input logic [4:0] acode, input logic [4:0] fcode);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'b0, fcode, acode, letter};
    do @(posedge clk); while (!s_tready);
    pending_line_out.push_back(step_sequencer(cmd, letter, acode, fcode));
    beats_sent++;
  endtask

  // zero crossing; the data fields carry noise the block must ignore
  task automatic send_tick();
    offer_beat(CmdTick, 8'($urandom_range(255)), 5'($urandom_range(31)),
               5'($urandom_range(31)));
  endtask

  // sender holds off until the block has returned every owed result
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_line_out.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_gap(input logic [9:0] value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    gap_reg = value;
  endtask

  // crossings until the sequence finishes, with the odd send thrown in
  task automatic run_to_idle(input int send_pct);
    while (seq_phase != PH_IDLE) begin
      if ($urandom_range(99) < send_pct) begin
        offer_beat(CmdSend, 8'($urandom_range(255)), 5'($urandom_range(31)),
                   5'($urandom_range(31)));
      end else begin
        send_tick();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    line_out_t want;
    line_out_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = line_out_t'(m_tdata[3:0]);
      if (pending_line_out.size() == 0) begin
        $error("result beat %b with nothing outstanding", m_tdata);
        err_count++;
      end else begin
        want = pending_line_out.pop_front();
        check_field("burst", want.burst, got.burst);
        check_field("busy_res", want.busy, got.busy);
        check_field("rejected", want.rejected, got.rejected);
        check_field("done_res", want.done, got.done);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // idle crossings give all zeros; letters outside A..P are refused
  task automatic test_idle_and_bad_letters();
    send_tick();
    offer_beat(CmdSend, 8'h00, 5'd0, 5'd0);
    offer_beat(CmdSend, 8'hFF, 5'd31, 5'd31);
    offer_beat(CmdSend, "Q", 5'd1, 5'd1);
    offer_beat(CmdSend, "a", 5'd16, 5'd17);
    offer_beat(CmdSend, "@", 5'd5, 5'd9);
    send_tick();
  endtask

  // full sequence at the reset gap, with sends refused while busy
  task automatic test_reset_gap_sequence();
    offer_beat(CmdSend, "M", 5'd0, 5'd31);
    repeat (5) send_tick();
    offer_beat(CmdSend, "P", 5'd31, 5'd0);   // valid letter but busy
    while (seq_phase != PH_GAP) send_tick();
    offer_beat(CmdSend, 8'h00, 5'd0, 5'd31); // bad letter, busy still wins
    run_to_idle(0);
    send_tick();
  endtask

  // function frames right behind the address frames
  task automatic test_zero_gap();
    write_gap(10'd0);
    offer_beat(CmdSend, "J", 5'd16, 5'd17);
    run_to_idle(0);
  endtask

  // long gap cut short by lowering the register while counting
  task automatic test_gap_lowered();
    write_gap(10'd1023);
    offer_beat(CmdSend, "P", 5'd13, 5'd1);
    while (!(seq_phase == PH_GAP && gap_ticks >= 10'd10)) send_tick();
    write_gap(10'd4);
    run_to_idle(0);
    write_gap(10'd3);
  endtask

  task automatic run_sequence();
    offer_beat(CmdSend, HouseLetters[$urandom_range(15)], 5'($urandom_range(31)),
               5'($urandom_range(31)));
    run_to_idle(3);
    repeat ($urandom_range(0, 2)) send_tick();
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(1) == 1) begin
        offer_beat(CmdSend,
                   $urandom_range(1) ? HouseLetters[$urandom_range(15)] : 8'($urandom_range(255)),
                   5'($urandom_range(31)), 5'($urandom_range(31)));
      end else begin
        send_tick();
      end
    end
  endtask

  // mostly whole sequences, some stray beats, gap changed now and then
  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_beats);
    int stop_at;
    int pick;
    drain_results();
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        write_gap(pick < 2 ? 10'($urandom_range(0, 40)) : 10'($urandom_range(0, 6)));
      end else if (pick < 25) begin
        send_noise();
      end else begin
        run_sequence();
      end
    end
  endtask

  initial begin
    tx_idle_pct = 27;
    rx_idle_pct = 69;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_and_bad_letters();
    test_reset_gap_sequence();
    test_zero_gap();
    test_gap_lowered();
    test_random_traffic(27, 69, 230);
    test_random_traffic(69, 27, 230);
    test_random_traffic(0, 0, 230);

    drain_results();
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
